// ===== sv/statement_handle_table_core_defines.svh =====
// Assertion helpers for the handle table.
`ifndef STATEMENT_HANDLE_TABLE_CORE_DEFINES_SVH
`define STATEMENT_HANDLE_TABLE_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SHT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sht_pkg.sv =====
package sht_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 32;
  localparam logic [4:0]  OPEN_LIMIT_RST  = 5'd16;

  typedef enum logic [3:0] {
    OP_OPEN      = 4'd0,
    OP_BIND      = 4'd1,
    OP_CURSOR    = 4'd2,
    OP_EXECUTED  = 4'd3,
    OP_FETCH     = 4'd4,
    OP_EXHAUSTED = 4'd5,
    OP_POISON    = 4'd6,
    OP_CLOSE     = 4'd7,
    OP_CLOSE_ALL = 4'd8,
    OP_STATE     = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_MALFORMED   = 3'd1,
    STS_UNSUPPORTED = 3'd2,
    STS_LIMIT       = 3'd3,
    STS_BADSTATE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_OPEN      = 3'd0,
    PH_EXECUTED  = 3'd1,
    PH_FETCHING  = 3'd2,
    PH_EXHAUSTED = 3'd3,
    PH_POISONED  = 3'd4,
    PH_CLOSED    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EXEC
  } fsm_e;

  localparam logic [2:0] KIND_MAX = 3'd2;

endpackage

// ===== sv/statement_handle_table_core.sv =====
// Statement handle table: one item in, one result item out.
// The table memory is swept one entry a cycle through its single read port;
// a new item is taken while the previous result still waits in the output
// register.
// Reset (async, active low): valid marks clear, next id 1, count 0, limit 16.
`include "statement_handle_table_core_defines.svh"

module statement_handle_table_core #(
  parameter int unsigned MAX_ENTRIES = sht_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ID_BITS     = sht_pkg::ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,      // open_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // handle_id[31:0], sql_kind[34:32], cursor_id[66:35], rows_present[67], zero pad
  input  logic [71:0] s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,    // operation[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], new_handle[34:3], bound_cursor[66:35], entry_state[69:67],
  // hit[70], open_count[75:71], zero pad
  output logic [79:0] m_axis_tdata
);

  localparam int unsigned IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW    = (CW > 5) ? CW : 5;
  localparam int unsigned WORDW = ID_BITS + 32 + 3;

  // Table memory word: handle in the low bits, then cursor, then phase.
  logic [WORDW-1:0] mem_q [MAX_ENTRIES];
  logic [WORDW-1:0] rd_q;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [WORDW-1:0] mem_wd;

  sht_pkg::fsm_e    state_q, state_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]    live_q, live_d;
  logic [ID_BITS-1:0] next_q, next_d;
  logic [4:0]       limit_q;

  // Latched item.
  logic [3:0]  op_q;
  logic [31:0] hid_q, cur_q;
  logic [2:0]  kind_q;
  logic        rows_q;

  // Scan bookkeeping.
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pidx_q;
  logic          found_q, found_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [ID_BITS-1:0] f_hnd_q, f_hnd_d;
  logic [31:0]   f_cur_q, f_cur_d;
  logic [2:0]    f_ph_q, f_ph_d;
  logic          clash_q, clash_d;
  logic          free_q, free_d;
  logic [IW-1:0] fidx_q, fidx_d;

  // Output register.
  logic        ovalid_q, ovalid_d;
  logic [79:0] odata_q, odata_d;

  logic [ID_BITS-1:0] r_hnd;
  logic [31:0]        r_cur;
  logic [2:0]         r_ph;
  logic               accept;
  logic               out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == sht_pkg::FSM_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign out_free      = !ovalid_q || m_axis_tready;

  assign r_hnd = rd_q[ID_BITS-1:0];
  assign r_cur = rd_q[ID_BITS+31:ID_BITS];
  assign r_ph  = rd_q[WORDW-1:ID_BITS+32];

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sht_pkg::FSM_IDLE;
      valid_q  <= '0;
      live_q   <= '0;
      next_q   <= ID_BITS'(1);
      limit_q  <= sht_pkg::OPEN_LIMIT_RST;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      live_q   <= live_d;
      next_q   <= next_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= s_axis_tuser;
      hid_q  <= s_axis_tdata[31:0];
      kind_q <= s_axis_tdata[34:32];
      cur_q  <= s_axis_tdata[66:35];
      rows_q <= s_axis_tdata[67];
    end
    pidx_q  <= idx_q[IW-1:0];
    found_q <= found_d;
    slot_q  <= slot_d;
    f_hnd_q <= f_hnd_d;
    f_cur_q <= f_cur_d;
    f_ph_q  <= f_ph_d;
    clash_q <= clash_d;
    free_q  <= free_d;
    fidx_q  <= fidx_d;
    odata_q <= odata_d;
  end

  always_comb begin
    logic [2:0]  st;
    logic [31:0] new_h, bcur;
    logic [2:0]  est;
    logic        hit;
    logic [LW-1:0] lim;
    logic        is_hop;

    state_d  = state_q;
    valid_d  = valid_q;
    live_d   = live_q;
    next_d   = next_q;
    idx_d    = idx_q;
    pend_d   = 1'b0;
    found_d  = found_q;
    slot_d   = slot_q;
    f_hnd_d  = f_hnd_q;
    f_cur_d  = f_cur_q;
    f_ph_d   = f_ph_q;
    clash_d  = clash_q;
    free_d   = free_q;
    fidx_d   = fidx_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    mem_we   = 1'b0;
    mem_wa   = slot_q;
    mem_wd   = {f_ph_q, f_cur_q, f_hnd_q};
    st       = sht_pkg::STS_OK;
    new_h    = '0;
    bcur     = '0;
    est      = sht_pkg::PH_OPEN;
    hit      = 1'b0;
    lim      = (LW'(limit_q) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(limit_q);
    is_hop   = (op_q >= 4'(sht_pkg::OP_BIND)) && (op_q <= 4'(sht_pkg::OP_POISON));

    case (state_q)
      sht_pkg::FSM_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          found_d = 1'b0;
          clash_d = 1'b0;
          free_d  = 1'b0;
          state_d = sht_pkg::FSM_SCAN;
        end
      end
      sht_pkg::FSM_SCAN: begin
        // Issue one read a cycle, evaluate the entry read the cycle before.
        if (idx_q < CW'(MAX_ENTRIES)) begin
          idx_d  = idx_q + CW'(1);
          pend_d = 1'b1;
        end else if (!pend_q) begin
          state_d = sht_pkg::FSM_EXEC;
        end
        if (pend_q) begin
          if (valid_q[pidx_q]) begin
            if (!found_q && (32'(r_hnd) == hid_q)) begin
              found_d = 1'b1;
              slot_d  = pidx_q;
              f_hnd_d = r_hnd;
              f_cur_d = r_cur;
              f_ph_d  = r_ph;
            end
            if (r_cur == cur_q) begin
              clash_d = 1'b1;
            end
          end else if (!free_q) begin
            free_d = 1'b1;
            fidx_d = pidx_q;
          end
        end
      end
      sht_pkg::FSM_EXEC: begin
        if (out_free) begin
          if (is_hop) begin
            if (hid_q == '0) begin
              st = sht_pkg::STS_MALFORMED;
            end else if (!found_q) begin
              st = sht_pkg::STS_BADSTATE;
            end
          end
          case (op_q)
            sht_pkg::OP_OPEN: begin
              if (kind_q > sht_pkg::KIND_MAX) begin
                st = sht_pkg::STS_UNSUPPORTED;
              end else if ((LW'(live_q) >= lim) || !free_q) begin
                st = sht_pkg::STS_LIMIT;
              end else if ((next_q == '0) || (next_q == '1)) begin
                st = sht_pkg::STS_LIMIT;
              end else begin
                valid_d[fidx_q] = 1'b1;
                mem_we = 1'b1;
                mem_wa = fidx_q;
                mem_wd = {sht_pkg::PH_OPEN, 32'd0, next_q};
                new_h  = 32'(next_q);
                next_d = next_q + ID_BITS'(1);
                live_d = live_q + CW'(1);
              end
            end
            sht_pkg::OP_BIND: begin
              if (st == sht_pkg::STS_OK) begin
                if ((cur_q == '0) || (f_cur_q != '0) || clash_q) begin
                  st = sht_pkg::STS_MALFORMED;
                end else begin
                  mem_we = 1'b1;
                  mem_wd = {f_ph_q, cur_q, f_hnd_q};
                end
              end
            end
            sht_pkg::OP_CURSOR: begin
              if (st == sht_pkg::STS_OK) begin
                if (f_cur_q == '0) begin
                  st = sht_pkg::STS_BADSTATE;
                end else begin
                  bcur = f_cur_q;
                  hit  = 1'b1;
                end
              end
            end
            sht_pkg::OP_EXECUTED: begin
              if (st == sht_pkg::STS_OK) begin
                if (f_ph_q != sht_pkg::PH_OPEN) begin
                  st = sht_pkg::STS_BADSTATE;
                end else begin
                  mem_we = 1'b1;
                  mem_wd = {(rows_q ? sht_pkg::PH_EXECUTED : sht_pkg::PH_EXHAUSTED),
                            f_cur_q, f_hnd_q};
                end
              end
            end
            sht_pkg::OP_FETCH, sht_pkg::OP_EXHAUSTED: begin
              if (st == sht_pkg::STS_OK) begin
                if ((f_ph_q != sht_pkg::PH_EXECUTED) && (f_ph_q != sht_pkg::PH_FETCHING)) begin
                  st = sht_pkg::STS_BADSTATE;
                end else begin
                  mem_we = 1'b1;
                  mem_wd = {((op_q == sht_pkg::OP_FETCH) ? sht_pkg::PH_FETCHING
                                                         : sht_pkg::PH_EXHAUSTED),
                            f_cur_q, f_hnd_q};
                end
              end
            end
            sht_pkg::OP_POISON: begin
              if (st == sht_pkg::STS_OK) begin
                mem_we = 1'b1;
                mem_wd = {sht_pkg::PH_POISONED, f_cur_q, f_hnd_q};
              end
            end
            sht_pkg::OP_CLOSE: begin
              if ((hid_q != '0) && found_q) begin
                valid_d[slot_q] = 1'b0;
                live_d = live_q - CW'(1);
                hit    = 1'b1;
              end
            end
            sht_pkg::OP_CLOSE_ALL: begin
              valid_d = '0;
              live_d  = '0;
            end
            sht_pkg::OP_STATE: begin
              if (hid_q == '0) begin
                st = sht_pkg::STS_MALFORMED;
              end else begin
                est = found_q ? f_ph_q : sht_pkg::PH_CLOSED;
              end
            end
            default: begin
              st = sht_pkg::STS_MALFORMED;
            end
          endcase
          ovalid_d = 1'b1;
          odata_d  = {4'd0, 5'(live_d), hit, est, bcur, new_h, st};
          state_d  = sht_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = sht_pkg::FSM_IDLE;
      end
    endcase
  end

  // Valid marks and the open count must agree.
  `SHT_ASSERT(a_count_match, $countones(valid_q) == 32'(live_q), "open count drift")
  // An accepted item always starts a table sweep.
  `SHT_ASSERT_NEXT(a_accept_scan, accept, state_q == sht_pkg::FSM_SCAN, "no sweep")
  // A result appears only when the execute step finishes.
  `SHT_ASSERT(a_out_source, !$rose(ovalid_q) || $past(state_q == sht_pkg::FSM_EXEC),
              "stray result")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SLOTS     = sht_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned DRAIN_CYC = SLOTS + 10;

  // one expected answer of the table
  typedef struct packed {
    sht_pkg::status_e status;
    logic [31:0]      new_handle;
    logic [31:0]      bound_cursor;
    sht_pkg::phase_e  entry_state;
    logic             hit;
    logic [4:0]       open_count;
  } answer_t;

  // Mirror of the handle table plus the queue of answers still owed.
  class handle_table_sb;
    logic [4:0]      limit;
    bit              live [SLOTS];
    logic [31:0]     id_of [SLOTS];
    logic [31:0]     cur_of [SLOTS];
    sht_pkg::phase_e ph_of [SLOTS];
    logic [31:0]     next_id;
    logic [4:0]      count;
    answer_t         owed [$];
    int unsigned     errors;

    function new();
      limit   = sht_pkg::OPEN_LIMIT_RST;
      next_id = 32'd1;
      count   = '0;
      errors  = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function int lookup(logic [31:0] hid);
      foreach (live[i]) if (live[i] && id_of[i] == hid) return i;
      return -1;
    endfunction

    // Apply one accepted request to the mirror and queue its answer.
    function void note_item(logic [3:0] op, logic [31:0] hid, logic [2:0] kind,
                            logic [31:0] cur, logic rows);
      answer_t a;
      int s;
      int f;
      int lim;
      a = '{status: sht_pkg::STS_OK, new_handle: '0, bound_cursor: '0,
            entry_state: sht_pkg::PH_OPEN, hit: 1'b0, open_count: '0};
      s = -1;
      // handle operations first resolve their entry
      if (op >= sht_pkg::OP_BIND && op <= sht_pkg::OP_POISON) begin
        if (hid == '0) a.status = sht_pkg::STS_MALFORMED;
        else begin
          s = lookup(hid);
          if (s < 0) a.status = sht_pkg::STS_BADSTATE;
        end
      end
      case (op)
        sht_pkg::OP_OPEN: begin
          lim = (limit > SLOTS) ? SLOTS : limit;
          f = -1;
          foreach (live[i]) if (!live[i] && f < 0) f = i;
          if (kind > sht_pkg::KIND_MAX) a.status = sht_pkg::STS_UNSUPPORTED;
          else if (count >= lim || f < 0) a.status = sht_pkg::STS_LIMIT;
          else if (next_id == '0 || next_id == '1) a.status = sht_pkg::STS_LIMIT;
          else begin
            live[f]   = 1'b1;
            id_of[f]  = next_id;
            cur_of[f] = '0;
            ph_of[f]  = sht_pkg::PH_OPEN;
            a.new_handle = next_id;
            next_id++;
            count++;
          end
        end
        sht_pkg::OP_BIND: if (a.status == sht_pkg::STS_OK) begin
          if (cur == '0 || cur_of[s] != '0) a.status = sht_pkg::STS_MALFORMED;
          else begin
            foreach (live[i])
              if (live[i] && cur_of[i] == cur) a.status = sht_pkg::STS_MALFORMED;
            if (a.status == sht_pkg::STS_OK) cur_of[s] = cur;
          end
        end
        sht_pkg::OP_CURSOR: if (a.status == sht_pkg::STS_OK) begin
          if (cur_of[s] == '0) a.status = sht_pkg::STS_BADSTATE;
          else begin
            a.bound_cursor = cur_of[s];
            a.hit = 1'b1;
          end
        end
        sht_pkg::OP_EXECUTED: if (a.status == sht_pkg::STS_OK) begin
          if (ph_of[s] != sht_pkg::PH_OPEN) a.status = sht_pkg::STS_BADSTATE;
          else ph_of[s] = rows ? sht_pkg::PH_EXECUTED : sht_pkg::PH_EXHAUSTED;
        end
        sht_pkg::OP_FETCH, sht_pkg::OP_EXHAUSTED: if (a.status == sht_pkg::STS_OK) begin
          if (ph_of[s] != sht_pkg::PH_EXECUTED && ph_of[s] != sht_pkg::PH_FETCHING)
            a.status = sht_pkg::STS_BADSTATE;
          else
            ph_of[s] = (op == sht_pkg::OP_FETCH) ? sht_pkg::PH_FETCHING
                                                 : sht_pkg::PH_EXHAUSTED;
        end
        sht_pkg::OP_POISON:
          if (a.status == sht_pkg::STS_OK) ph_of[s] = sht_pkg::PH_POISONED;
        sht_pkg::OP_CLOSE: if (hid != '0) begin
          s = lookup(hid);
          if (s >= 0) begin
            live[s] = 1'b0;
            count--;
            a.hit = 1'b1;
          end
        end
        sht_pkg::OP_CLOSE_ALL: begin
          foreach (live[i]) live[i] = 1'b0;
          count = '0;
        end
        sht_pkg::OP_STATE: begin
          if (hid == '0) a.status = sht_pkg::STS_MALFORMED;
          else begin
            s = lookup(hid);
            a.entry_state = (s < 0) ? sht_pkg::PH_CLOSED : ph_of[s];
          end
        end
        default: a.status = sht_pkg::STS_MALFORMED;
      endcase
      a.open_count = count;
      owed.push_back(a);
    endfunction

    // Compare one delivered answer with the oldest one owed.
    function void check_result(logic [79:0] data);
      answer_t want;
      answer_t got;
      got = answer_t'({data[2:0], data[34:3], data[66:35], data[69:67], data[70],
                       data[75:71]});
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", data);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sts %0d/%0d new %h/%h cur %h/%h st %0d/%0d hit %b/%b cnt %0d/%0d",
                   want.status, got.status, want.new_handle, got.new_handle,
                   want.bound_cursor, got.bound_cursor, want.entry_state,
                   got.entry_state, want.hit, got.hit, want.open_count,
                   got.open_count);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;

  handle_table_sb sb;
  int unsigned    idle_pct;
  int unsigned    stall_pct;

  statement_handle_table_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Result side: stall at random, check every item taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one request; hold tvalid high across back-to-back items.
  task automatic send_item(logic [3:0] op, logic [31:0] hid, logic [2:0] kind,
                           logic [31:0] cur, logic rows);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, rows, cur, kind, hid};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, hid, kind, cur, rows);
  endtask

  // Drain all answers, let the sweep settle, then write the limit.
  task automatic write_limit(logic [4:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.limit = value;
  endtask

  // Random request biased toward recently allocated handles and a small cursor pool.
  task automatic send_random();
    logic [3:0]  op;
    logic [31:0] hid;
    logic [31:0] cur;
    logic [2:0]  kind;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 22) op = sht_pkg::OP_OPEN;
    else if (r < 32) op = sht_pkg::OP_CLOSE;
    else if (r < 34) op = sht_pkg::OP_CLOSE_ALL;
    else if (r < 37) op = 4'($urandom_range(15, 10));
    else op = 4'($urandom_range(sht_pkg::OP_STATE, sht_pkg::OP_BIND));
    r = $urandom_range(99);
    if (r < 80) hid = sb.next_id - 32'($urandom_range(20, 1));
    else if (r < 88) hid = '0;
    else hid = $urandom;
    r = $urandom_range(99);
    if (r < 70) cur = 32'($urandom_range(12, 1));
    else if (r < 80) cur = '0;
    else cur = $urandom;
    kind = ($urandom_range(99) < 80) ? 3'($urandom_range(sht_pkg::KIND_MAX))
                                     : 3'($urandom);
    send_item(op, hid, kind, cur, 1'($urandom));
  endtask

  initial begin
    logic [4:0] limits [8];
    sb = new();
    limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd16, 5'd9};
    idle_pct      = 0;
    stall_pct     = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at the reset limit: ids 1..3 get allocated here.
    send_item(sht_pkg::OP_OPEN, '0, 3'd0, '0, 1'b0);
    send_item(sht_pkg::OP_OPEN, '0, 3'd1, '0, 1'b0);
    send_item(sht_pkg::OP_OPEN, '0, 3'd2, '0, 1'b0);
    send_item(sht_pkg::OP_OPEN, '0, 3'd7, '0, 1'b0);          // unsupported kind
    send_item(sht_pkg::OP_BIND, 32'd1, '0, '1, 1'b0);
    send_item(sht_pkg::OP_BIND, 32'd2, '0, '1, 1'b0);         // cursor taken by another entry
    send_item(sht_pkg::OP_BIND, 32'd1, '0, 32'd5, 1'b0);      // rebind
    send_item(sht_pkg::OP_BIND, 32'd2, '0, '0, 1'b0);         // zero cursor
    send_item(sht_pkg::OP_BIND, '0, '0, 32'd5, 1'b0);         // zero handle
    send_item(sht_pkg::OP_CURSOR, 32'd1, '0, '0, 1'b0);
    send_item(sht_pkg::OP_CURSOR, 32'd2, '0, '0, 1'b0);       // unbound
    send_item(sht_pkg::OP_EXECUTED, 32'd1, '0, '0, 1'b1);
    send_item(sht_pkg::OP_FETCH, 32'd1, '0, '0, 1'b0);
    send_item(sht_pkg::OP_EXHAUSTED, 32'd1, '0, '0, 1'b0);
    send_item(sht_pkg::OP_EXECUTED, 32'd2, '0, '0, 1'b0);
    send_item(sht_pkg::OP_FETCH, 32'd2, '0, '0, 1'b0);        // wrong phase
    send_item(sht_pkg::OP_POISON, 32'd3, '0, '0, 1'b0);
    send_item(sht_pkg::OP_STATE, 32'd3, '0, '0, 1'b0);
    send_item(sht_pkg::OP_STATE, '1, '0, '0, 1'b0);           // unknown handle
    send_item(sht_pkg::OP_STATE, '0, '0, '0, 1'b0);
    send_item(sht_pkg::OP_EXECUTED, '1, '0, '0, 1'b0);        // unknown handle
    send_item(sht_pkg::OP_CLOSE, '0, '0, '0, 1'b0);
    send_item(sht_pkg::OP_CLOSE, 32'd1, '0, '0, 1'b0);
    send_item(4'd10, 32'd2, '0, '0, 1'b0);
    send_item(4'd15, '1, '1, '1, 1'b1);

    // Random phases: each writes a new limit and cycles the idle and stall pattern.
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int n = 0; n < 235; n++) send_random();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
